@@ rtl/core/psp_pkg.sv @@
// Package with the shared types, constants and register codes of the packet spool table.
package psp_pkg;

  localparam int TABLE_DEPTH_DEF = 8;

  localparam int MAC_W     = 32;
  localparam int SEQ_W     = 16;
  localparam int LQI_W     = 8;
  localparam int REP_W     = 8;
  localparam int PAY_W     = 64;
  localparam int QLEN_W    = 8;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 8;
  localparam int HOLD_W    = 24;
  localparam int INTV_W    = 16;
  localparam int OFFSET_W  = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_INTERVAL = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_QUEUE_FULL      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_UPLOAD_LIMIT    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOT_OFFSET     = 2'd3;

  localparam logic [INTV_W-1:0]   REPEAT_INTERVAL_RST = 16'd100;
  localparam logic [QLEN_W-1:0]   QUEUE_FULL_RST      = 8'd8;
  localparam logic [TIME_W-1:0]   UPLOAD_LIMIT_RST    = 32'd60000;
  localparam logic [OFFSET_W-1:0] SLOT_OFFSET_RST     = 7'd0;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NRDY = 2'd3;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [SEQ_W-1:0]  seq;
    logic [LQI_W-1:0]  lqi;
    logic [REP_W-1:0]  repeat_count;
    logic [PAY_W-1:0]  payload;
    logic              tx_now;
    logic              queue_ready;
    logic [QLEN_W-1:0] queue_length;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                register_mac;
    logic                enqueue_payload;
    logic [PAY_W-1:0]    payload_out;
    logic [HOLD_W-1:0]   hold_ms;
    logic                send;
    logic [TIME_W-1:0]   last_update_ms;
  } out_word_t;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [SEQ_W-1:0] seq;
    logic [LQI_W-1:0] lqi;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_addr;
  } sts_t;

endpackage

@@ rtl/core/psp_if.sv @@
// Stream interfaces for the packet input channel and the result channel.
interface psp_in_if;
  logic             valid;
  logic             ready;
  psp_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psp_out_if;
  logic              valid;
  logic              ready;
  psp_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/psp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/psp_ctrl.sv @@
// Controller state machine that sequences accept, table scan, commit and result handoff.
module psp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output psp_pkg::cmd_t cmd,
  input  psp_pkg::sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_addr) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/psp_dp.sv @@
// Datapath with the entry table, scan trackers, send limiter, configuration and result register.
module psp_dp #(
  parameter int TABLE_DEPTH = psp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psp_pkg::in_word_t                  in_data,
  output psp_pkg::out_word_t                 out_data,
  input  logic                               cfg_we,
  input  logic [psp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [psp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  psp_pkg::cmd_t                      cmd,
  output psp_pkg::sts_t                      sts
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENT_W = $bits(psp_pkg::entry_t);

  psp_pkg::in_word_t item_r;

  logic [psp_pkg::INTV_W-1:0]   interval_r;
  logic [psp_pkg::QLEN_W-1:0]   qfull_r;
  logic [psp_pkg::TIME_W-1:0]   limit_r;
  logic [psp_pkg::OFFSET_W-1:0] offset_r;

  logic [psp_pkg::TIME_W-1:0]   send_count_r;
  logic [psp_pkg::TIME_W-1:0]   last_update_r;
  logic [2*psp_pkg::TIME_W-1:0] prod_r;
  logic [psp_pkg::HOLD_W-1:0]   hold_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0]       scan_addr_r;
  logic                   chk_vld_r;
  logic                   chk_ok_r;
  logic [IDX_W-1:0]       chk_idx_r;
  logic [ENT_W-1:0]       rdata;
  psp_pkg::entry_t        ent;

  logic                       hit_r;
  logic [IDX_W-1:0]           hit_idx_r;
  logic [psp_pkg::SEQ_W-1:0]  hit_seq_r;
  logic                       emp_r;
  logic [IDX_W-1:0]           emp_idx_r;
  logic                       min_vld_r;
  logic [psp_pkg::LQI_W-1:0]  min_lqi_r;
  logic [IDX_W-1:0]           min_idx_r;

  logic               dup;
  logic               drop;
  logic               upd;
  logic [IDX_W-1:0]   sel_idx;
  logic               limited;
  logic               tx;
  psp_pkg::entry_t    wr_ent;
  psp_pkg::out_word_t res;
  psp_pkg::out_word_t out_r;

  assign sts.last_addr = (scan_addr_r == IDX_W'(TABLE_DEPTH - 1));

  psp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit && upd),
    .waddr (sel_idx),
    .wdata (wr_ent),
    .raddr (scan_addr_r),
    .rdata (rdata)
  );

  assign ent = chk_ok_r ? psp_pkg::entry_t'(rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= psp_pkg::REPEAT_INTERVAL_RST;
      qfull_r <= psp_pkg::QUEUE_FULL_RST;
      limit_r <= psp_pkg::UPLOAD_LIMIT_RST;
      offset_r <= psp_pkg::SLOT_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        psp_pkg::REG_REPEAT_INTERVAL: interval_r <= cfg_wdata[psp_pkg::INTV_W-1:0];
        psp_pkg::REG_QUEUE_FULL:      qfull_r <= cfg_wdata[psp_pkg::QLEN_W-1:0];
        psp_pkg::REG_UPLOAD_LIMIT:    limit_r <= cfg_wdata;
        psp_pkg::REG_SLOT_OFFSET:     offset_r <= cfg_wdata[psp_pkg::OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    prod_r <= send_count_r * limit_r;
    hold_r <= psp_pkg::HOLD_W'(item_r.repeat_count * interval_r);
    chk_idx_r <= scan_addr_r;
    chk_ok_r <= valid_r[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      chk_vld_r <= 1'b0;
      valid_r <= '0;
    end else begin
      chk_vld_r <= cmd.scan;
      if (cmd.load) begin
        scan_addr_r <= '0;
      end else if (cmd.scan) begin
        scan_addr_r <= scan_addr_r + 1'b1;
      end
      if (cmd.commit && upd) begin
        valid_r[sel_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      emp_r <= 1'b0;
      min_vld_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r <= 1'b0;
      emp_r <= 1'b0;
      min_vld_r <= 1'b0;
    end else if (chk_vld_r) begin
      if (!hit_r && (ent.mac == item_r.mac)) begin
        hit_r <= 1'b1;
        hit_idx_r <= chk_idx_r;
        hit_seq_r <= ent.seq;
      end
      if (!emp_r && (ent.mac == '0)) begin
        emp_r <= 1'b1;
        emp_idx_r <= chk_idx_r;
      end
      if (!min_vld_r || (ent.lqi < min_lqi_r)) begin
        min_vld_r <= 1'b1;
        min_lqi_r <= ent.lqi;
        min_idx_r <= chk_idx_r;
      end
    end
  end

  always_comb begin
    dup = hit_r && (hit_seq_r == item_r.seq);
    drop = !hit_r && !emp_r && (min_lqi_r > item_r.lqi);
    upd = !dup && !drop;
    if (hit_r) begin
      sel_idx = hit_idx_r;
    end else if (emp_r) begin
      sel_idx = emp_idx_r;
    end else begin
      sel_idx = min_idx_r;
    end
    wr_ent.mac = item_r.mac;
    wr_ent.seq = item_r.seq;
    wr_ent.lqi = item_r.lqi;
    limited = (send_count_r != '0) &&
              ({{psp_pkg::TIME_W{1'b0}}, item_r.now_ms} < prod_r);
    tx = (item_r.tx_now || (item_r.queue_length >= qfull_r)) && !limited;

    res = '0;
    res.last_update_ms = last_update_r;
    if (dup) begin
      res.status = psp_pkg::ST_DUP;
    end else if (drop) begin
      res.status = psp_pkg::ST_DROP;
    end else begin
      res.slot_index = psp_pkg::SLOT_W'(sel_idx) + psp_pkg::SLOT_W'(offset_r);
      res.register_mac = !hit_r;
      res.enqueue_payload = 1'b1;
      res.payload_out = item_r.payload;
      res.hold_ms = hold_r;
      if (!item_r.queue_ready) begin
        res.status = psp_pkg::ST_NRDY;
      end else begin
        res.status = psp_pkg::ST_OK;
        res.send = tx;
        res.last_update_ms = item_r.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_count_r <= '0;
      last_update_r <= '0;
    end else if (cmd.commit && upd && item_r.queue_ready) begin
      last_update_r <= item_r.now_ms;
      if (tx) begin
        send_count_r <= send_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/core/packet_spool_table.sv @@
// Top level of the packet spool table: controller, datapath and stream channels.
// The next word is accepted only after the current one is committed; the table scan reads one entry per cycle.
// A finished result waits in an output register while the next word is accepted.
// Reset is synchronous and active low; it empties the table at once and loads register defaults.
module packet_spool_table #(
  parameter int TABLE_DEPTH = psp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  psp_in_if.sink                         in_chan,
  psp_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [psp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [psp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  psp_pkg::cmd_t cmd;
  psp_pkg::sts_t sts;

  psp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  psp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_chan.data),
    .out_data  (out_chan.data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ rtl/core/psp_checker.sv @@
// Port-level assertions for the packet spool table and the bind that attaches them.
module psp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [psp_pkg::STATUS_W-1:0] status,
  input logic                         send,
  input logic                         enqueue_payload,
  input logic                         register_mac,
  input logic [psp_pkg::HOLD_W-1:0]   hold_ms
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a word is in progress");

  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == psp_pkg::ST_DUP || status == psp_pkg::ST_DROP) |->
      !send && !enqueue_payload && !register_mac && (hold_ms == '0))
    else $error("duplicate or dropped word carries enqueue fields");

  a_send_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && send |-> status == psp_pkg::ST_OK)
    else $error("send raised on a word that was not an ok update");

endmodule

bind packet_spool_table psp_checker u_psp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .status          (out_chan.data.status),
  .send            (out_chan.data.send),
  .enqueue_payload (out_chan.data.enqueue_payload),
  .register_mac    (out_chan.data.register_mac),
  .hold_ms         (out_chan.data.hold_ms)
);
